>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// edge of clk and is switched off while the synchronous reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/dalrf_pkg.sv
package dalrf_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ADDR_W        = 32;
  localparam int TIME_W        = 48;
  localparam int ENTRY_W       = ADDR_W + TIME_W;
  localparam int INTERVAL_W    = 32;
  localparam int LEN_W         = 8;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 32;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST = INTERVAL_W'(60000);
  localparam logic [LEN_W-1:0]      MAX_LENGTH_RST   = LEN_W'(182);

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_PACKET = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_ADDED     = 4'd0,
    ST_FULL      = 4'd1,
    ST_REMOVED   = 4'd2,
    ST_NOT_FOUND = 4'd3,
    ST_CLEARED   = 4'd4,
    ST_FORWARDED = 4'd5,
    ST_UNLISTED  = 4'd6,
    ST_TOO_SOON  = 4'd7,
    ST_TOO_LARGE = 4'd8
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_INTERVAL = 8'd0,
    CFG_MAX_LENGTH   = 8'd1
  } cfg_reg_t;

endpackage

>>> rtl/dalrf_ram.sv
module dalrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/device_allowlist_rate_filter.sv
// Channel    Direction  Transfer condition         Payload
// command    in         start && !busy             in_mode, in_dev_addr, in_now_time,
//                                                  in_payload_length
// result     out        out_strobe (one cycle)     out_status, out_forward, out_listed,
//                                                  out_last_seen
// config     in         cfg_valid && cfg_ready     cfg_index, cfg_wdata
//
// A clear command needs no scan; its result is shown in the cycle after the
// transfer. Add, remove and packet commands scan the table one entry per cycle
// through the single read port of the table RAM: they first prime the RAM read
// and then examine the entries in order, and a packet that finds its device
// then passes through a time check.
// busy stays high for the whole scan. The result receiver cannot stall; each
// result is a one-cycle strobe. rst_n is synchronous and active low; after it
// the table is empty and both configuration registers hold their defaults.
`include "assert_macros.svh"

module device_allowlist_rate_filter
  import dalrf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_mode,
  input  logic [ADDR_W-1:0]     in_dev_addr,
  input  logic [TIME_W-1:0]     in_now_time,
  input  logic [LEN_W-1:0]      in_payload_length,

  output logic                  out_strobe,
  output logic [3:0]            out_status,
  output logic                  out_forward,
  output logic                  out_listed,
  output logic [TIME_W-1:0]     out_last_seen,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRIME,
    S_SCAN,
    S_JUDGE
  } state_t;

  // Control state.
  state_t                  state_r, state_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic                    out_strobe_r, out_strobe_nxt;
  logic [INTERVAL_W-1:0]   min_interval_r, min_interval_nxt;
  logic [LEN_W-1:0]        max_length_r, max_length_nxt;
  idx_t                    chk_idx_r, chk_idx_nxt;
  idx_t                    rd_idx_r, rd_idx_nxt;
  idx_t                    hit_idx_r, hit_idx_nxt;
  logic                    any_hit_r, any_hit_nxt;

  // Command and result payload.
  mode_t                   mode_r, mode_nxt;
  logic [ADDR_W-1:0]       addr_r, addr_nxt;
  logic [TIME_W-1:0]       now_r, now_nxt;
  logic [LEN_W-1:0]        len_r, len_nxt;
  logic [TIME_W-1:0]       last_r, last_nxt;
  status_t                 status_r, status_nxt;
  logic                    forward_r, forward_nxt;
  logic                    listed_r, listed_nxt;
  logic [TIME_W-1:0]       seen_r, seen_nxt;

  // Table RAM ports.
  logic                    ram_we;
  idx_t                    ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic [ENTRY_W-1:0]      ram_rdata;

  // Entry under examination and the shared address comparator.
  logic                    e_valid;
  logic [ADDR_W-1:0]       e_addr;
  logic [TIME_W-1:0]       e_time;
  logic                    addr_eq;
  logic                    addr_zero;
  logic                    hit;
  logic                    at_last;

  // Time check.
  logic [TIME_W:0]         elapsed;
  logic                    too_soon;

  logic                    accept;

  // Each entry holds the device address above its last forward time. An entry
  // whose valid bit is clear reads as empty, so reset and clear never have to
  // sweep the RAM.
  dalrf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign e_valid   = valid_r[chk_idx_r];
  assign e_addr    = ram_rdata[ENTRY_W-1:TIME_W];
  assign e_time    = ram_rdata[TIME_W-1:0];
  assign addr_eq   = (e_addr == addr_r);
  assign addr_zero = (addr_r == '0);
  // Address zero is never a listed device.
  assign hit       = e_valid && addr_eq && !addr_zero;
  assign at_last   = (chk_idx_r == LAST_IDX);

  // A stored time ahead of the current one shows up as a borrow and counts
  // as too soon.
  assign elapsed   = {1'b0, now_r} - {1'b0, last_r};
  assign too_soon  = elapsed[TIME_W] ||
                     (elapsed[TIME_W-1:0] < {{(TIME_W-INTERVAL_W){1'b0}}, min_interval_r});

  always_comb begin
    state_nxt        = state_r;
    valid_nxt        = valid_r;
    out_strobe_nxt   = 1'b0;
    min_interval_nxt = min_interval_r;
    max_length_nxt   = max_length_r;
    chk_idx_nxt      = chk_idx_r;
    rd_idx_nxt       = rd_idx_r;
    hit_idx_nxt      = hit_idx_r;
    any_hit_nxt      = any_hit_r;
    mode_nxt         = mode_r;
    addr_nxt         = addr_r;
    now_nxt          = now_r;
    len_nxt          = len_r;
    last_nxt         = last_r;
    status_nxt       = status_r;
    forward_nxt      = forward_r;
    listed_nxt       = listed_r;
    seen_nxt         = seen_r;
    ram_we           = 1'b0;
    ram_waddr        = chk_idx_r;
    ram_wdata        = {addr_r, {TIME_W{1'b0}}};

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_INTERVAL: min_interval_nxt = cfg_wdata[INTERVAL_W-1:0];
        CFG_MAX_LENGTH:   max_length_nxt   = cfg_wdata[LEN_W-1:0];
        default:          ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt    = mode_t'(in_mode);
          addr_nxt    = in_dev_addr;
          now_nxt     = in_now_time;
          len_nxt     = in_payload_length;
          rd_idx_nxt  = '0;
          any_hit_nxt = 1'b0;
          if (mode_t'(in_mode) == MODE_CLEAR) begin
            valid_nxt      = '0;
            out_strobe_nxt = 1'b1;
            status_nxt     = ST_CLEARED;
            forward_nxt    = 1'b0;
            listed_nxt     = 1'b0;
            seen_nxt       = '0;
          end else begin
            state_nxt = S_PRIME;
          end
        end
      end

      S_PRIME: begin
        chk_idx_nxt = rd_idx_r;
        rd_idx_nxt  = rd_idx_r + 1'b1;
        state_nxt   = S_SCAN;
      end

      S_SCAN: begin
        chk_idx_nxt = rd_idx_r;
        rd_idx_nxt  = rd_idx_r + 1'b1;
        forward_nxt = 1'b0;
        listed_nxt  = 1'b0;
        seen_nxt    = '0;
        case (mode_r)
          MODE_ADD: begin
            if (!e_valid || hit) begin
              if (!addr_zero) begin
                ram_we               = 1'b1;
                valid_nxt[chk_idx_r] = 1'b1;
              end
              out_strobe_nxt = 1'b1;
              status_nxt     = ST_ADDED;
              state_nxt      = S_IDLE;
            end else if (at_last) begin
              out_strobe_nxt = 1'b1;
              status_nxt     = ST_FULL;
              state_nxt      = S_IDLE;
            end
          end
          MODE_REMOVE: begin
            if (hit) begin
              valid_nxt[chk_idx_r] = 1'b0;
              any_hit_nxt          = 1'b1;
            end
            if (at_last) begin
              out_strobe_nxt = 1'b1;
              status_nxt     = (any_hit_r || hit) ? ST_REMOVED : ST_NOT_FOUND;
              state_nxt      = S_IDLE;
            end
          end
          MODE_PACKET: begin
            if (hit) begin
              last_nxt    = e_time;
              hit_idx_nxt = chk_idx_r;
              state_nxt   = S_JUDGE;
            end else if (at_last) begin
              out_strobe_nxt = 1'b1;
              status_nxt     = ST_UNLISTED;
              state_nxt      = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_JUDGE: begin
        out_strobe_nxt = 1'b1;
        listed_nxt     = 1'b1;
        seen_nxt       = last_r;
        forward_nxt    = 1'b0;
        state_nxt      = S_IDLE;
        ram_waddr      = hit_idx_r;
        ram_wdata      = {addr_r, now_r};
        if (too_soon) begin
          status_nxt = ST_TOO_SOON;
        end else if (len_r > max_length_r) begin
          status_nxt = ST_TOO_LARGE;
        end else begin
          ram_we      = 1'b1;
          forward_nxt = 1'b1;
          status_nxt  = ST_FORWARDED;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    addr_r    <= addr_nxt;
    now_r     <= now_nxt;
    len_r     <= len_nxt;
    last_r    <= last_nxt;
    status_r  <= status_nxt;
    forward_r <= forward_nxt;
    listed_r  <= listed_nxt;
    seen_r    <= seen_nxt;
    chk_idx_r <= chk_idx_nxt;
    rd_idx_r  <= rd_idx_nxt;
    hit_idx_r <= hit_idx_nxt;
    any_hit_r <= any_hit_nxt;
    if (!rst_n) begin
      state_r        <= S_IDLE;
      valid_r        <= '0;
      out_strobe_r   <= 1'b0;
      min_interval_r <= MIN_INTERVAL_RST;
      max_length_r   <= MAX_LENGTH_RST;
    end else begin
      state_r        <= state_nxt;
      valid_r        <= valid_nxt;
      out_strobe_r   <= out_strobe_nxt;
      min_interval_r <= min_interval_nxt;
      max_length_r   <= max_length_nxt;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_status    = status_r;
  assign out_forward   = forward_r;
  assign out_listed    = listed_r;
  assign out_last_seen = seen_r;

  // A forwarded packet always comes from a listed device.
  `ASSERT_CLK(a_fwd_listed,
    out_strobe && out_forward |-> out_listed && (out_status == ST_FORWARDED),
    "forward reported without a listed device")

  // Every command other than clear starts a table scan.
  `ASSERT_CLK(a_scan_starts,
    accept && (in_mode != MODE_CLEAR) |=> busy,
    "accepted command did not start a scan")

  // A result follows either the end of a scan or a clear transfer.
  `ASSERT_CLK(a_result_source,
    out_strobe |-> $past(busy) || $past(accept),
    "result strobe without a finished command")

  // The table RAM is written only while a command is being worked on.
  `ASSERT_NEVER(a_write_idle,
    ram_we && ((state_r == S_IDLE) || (state_r == S_PRIME)),
    "table written outside a scan or time check")

  // An address of zero never becomes a valid entry.
  `ASSERT_NEVER(a_zero_addr_write,
    ram_we && addr_zero,
    "empty address written into the table")

endmodule

>>> tb/sv/testbench.sv
module testbench;
  import dalrf_pkg::*;

  // Overall shape of the run: reset, a short table of hand-picked commands, then eight
  // phases of random traffic. Each phase first lets the filter go idle and then loads a
  // new pair of rate rules. Every accepted command runs through the predictor below,
  // which keeps its own copy of the allowlist and of the rules. The monitor compares
  // each result strobe with the oldest expected result.

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int DRAIN_CYCLES  = 24;
  localparam int RULE_PHASES   = 8;
  localparam int PHASE_ITEMS   = 230;
  localparam int POOL_SIZE     = 20;
  localparam int OPENING_ROWS  = 26;
  localparam int WATCHDOG_TIME = 10_000_000;

  // Register indexes at or above this one are not mapped. A write to them must leave
  // both rules unchanged.
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNMAPPED = CFG_IDX_W'(2);

  typedef struct {
    mode_t               mode;
    logic [ADDR_W-1:0]   addr;
    logic [TIME_W-1:0]   now;
    logic [LEN_W-1:0]    len;
  } filter_cmd_t;

  typedef struct {
    status_t             status;
    logic                fwd;
    logic                listed;
    logic [TIME_W-1:0]   seen;
  } filter_result_t;

  // One line of the opening table. The reps field repeats the command with the address
  // counting up, which is how the table gets filled. The known_result flag marks rows
  // whose outcome is written out by hand. All other rows take the predicted result.
  typedef struct {
    mode_t               mode;
    logic [ADDR_W-1:0]   addr;
    logic [TIME_W-1:0]   now;
    logic [LEN_W-1:0]    len;
    int                  reps;
    bit                  known_result;
    status_t             status;
    logic                fwd;
    logic                listed;
    logic [TIME_W-1:0]   seen;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [1:0]            in_mode;
  logic [ADDR_W-1:0]     in_dev_addr;
  logic [TIME_W-1:0]     in_now_time;
  logic [LEN_W-1:0]      in_payload_length;
  logic                  out_strobe;
  logic [3:0]            out_status;
  logic                  out_forward;
  logic                  out_listed;
  logic [TIME_W-1:0]     out_last_seen;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predictor state. This is the allowlist as the filter should hold it, together with
  // the rules that are currently in force.
  logic [ADDR_W-1:0]     allow_addr [TABLE_ENTRIES];
  logic [TIME_W-1:0]     allow_time [TABLE_ENTRIES];
  logic [INTERVAL_W-1:0] rule_min_interval;
  logic [LEN_W-1:0]      rule_max_length;

  filter_result_t        pending_results [$];
  logic [ADDR_W-1:0]     addr_pool [POOL_SIZE];
  logic [TIME_W-1:0]     sweep_clock;
  int                    error_count;
  int                    commands_sent;
  int                    status_tally [16];

  // The opening table starts from reset defaults: a 60000 interval and a 182 byte limit.
  plan_row_t opening_plan [OPENING_ROWS] = '{
    // The table is empty, so lookups and removes miss.
    '{MODE_PACKET, 32'd5, 48'd0, 8'd0, 1, 1'b1, ST_UNLISTED, 1'b0, 1'b0, 48'd0},
    '{MODE_REMOVE, 32'd5, 48'd0, 8'd0, 1, 1'b1, ST_NOT_FOUND, 1'b0, 1'b0, 48'd0},
    '{MODE_REMOVE, 32'd0, 48'd0, 8'd0, 1, 1'b1, ST_NOT_FOUND, 1'b0, 1'b0, 48'd0},
    // Address zero is accepted by add but never becomes a listed device.
    '{MODE_ADD, 32'd0, 48'd0, 8'd0, 1, 1'b1, ST_ADDED, 1'b0, 1'b0, 48'd0},
    '{MODE_PACKET, 32'd0, 48'hFFFF_FFFF_FFFF, 8'hFF, 1, 1'b1,
      ST_UNLISTED, 1'b0, 1'b0, 48'd0},
    '{MODE_ADD, 32'hFFFF_FFFF, 48'd0, 8'd0, 1, 1'b1, ST_ADDED, 1'b0, 1'b0, 48'd0},
    // A fresh entry carries time zero, so the interval counts from zero.
    '{MODE_PACKET, 32'hFFFF_FFFF, 48'd0, 8'd0, 1, 1'b1,
      ST_TOO_SOON, 1'b0, 1'b1, 48'd0},
    '{MODE_PACKET, 32'hFFFF_FFFF, 48'd60000, 8'd182, 1, 1'b1,
      ST_FORWARDED, 1'b1, 1'b1, 48'd0},
    // Time going backward, one tick short of the interval, then the length limit.
    '{MODE_PACKET, 32'hFFFF_FFFF, 48'd59999, 8'd0, 1, 1'b0,
      ST_ADDED, 1'b0, 1'b0, 48'd0},
    '{MODE_PACKET, 32'hFFFF_FFFF, 48'd119999, 8'd0, 1, 1'b0,
      ST_ADDED, 1'b0, 1'b0, 48'd0},
    '{MODE_PACKET, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'hFF, 1, 1'b0,
      ST_ADDED, 1'b0, 1'b0, 48'd0},
    '{MODE_PACKET, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'd182, 1, 1'b0,
      ST_ADDED, 1'b0, 1'b0, 48'd0},
    // Adding a device that is already listed resets its time to zero.
    '{MODE_ADD, 32'hFFFF_FFFF, 48'd0, 8'd0, 1, 1'b1, ST_ADDED, 1'b0, 1'b0, 48'd0},
    '{MODE_PACKET, 32'hFFFF_FFFF, 48'd60000, 8'd1, 1, 1'b0,
      ST_ADDED, 1'b0, 1'b0, 48'd0},
    // Addresses 1 to 15 go in, which fills every slot.
    '{MODE_ADD, 32'd1, 48'd0, 8'd0, 15, 1'b0, ST_ADDED, 1'b0, 1'b0, 48'd0},
    '{MODE_ADD, 32'd0, 48'd0, 8'd0, 1, 1'b1, ST_FULL, 1'b0, 1'b0, 48'd0},
    '{MODE_ADD, 32'h8000_0000, 48'd0, 8'd0, 1, 1'b1, ST_FULL, 1'b0, 1'b0, 48'd0},
    // With the table full, adding a device that is already listed still succeeds.
    '{MODE_ADD, 32'd7, 48'd0, 8'd0, 1, 1'b0, ST_ADDED, 1'b0, 1'b0, 48'd0},
    '{MODE_REMOVE, 32'd7, 48'd0, 8'd0, 1, 1'b0, ST_ADDED, 1'b0, 1'b0, 48'd0},
    // Device 9 lands in the freed slot, ahead of its existing copy. A lookup then finds
    // the lower copy, and a remove must clear both.
    '{MODE_ADD, 32'd9, 48'd0, 8'd0, 1, 1'b0, ST_ADDED, 1'b0, 1'b0, 48'd0},
    '{MODE_PACKET, 32'd9, 48'd70000, 8'd0, 1, 1'b0, ST_ADDED, 1'b0, 1'b0, 48'd0},
    '{MODE_REMOVE, 32'd9, 48'd0, 8'd0, 1, 1'b0, ST_ADDED, 1'b0, 1'b0, 48'd0},
    '{MODE_PACKET, 32'd9, 48'd80000, 8'd0, 1, 1'b0, ST_ADDED, 1'b0, 1'b0, 48'd0},
    '{MODE_ADD, 32'd0, 48'd0, 8'd0, 1, 1'b0, ST_ADDED, 1'b0, 1'b0, 48'd0},
    '{MODE_CLEAR, 32'd0, 48'd0, 8'd0, 1, 1'b1, ST_CLEARED, 1'b0, 1'b0, 48'd0},
    '{MODE_PACKET, 32'd1, 48'd90000, 8'd0, 1, 1'b1, ST_UNLISTED, 1'b0, 1'b0, 48'd0}
  };

  device_allowlist_rate_filter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_dev_addr       (in_dev_addr),
    .in_now_time       (in_now_time),
    .in_payload_length (in_payload_length),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_forward       (out_forward),
    .out_listed        (out_listed),
    .out_last_seen     (out_last_seen),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // The watchdog is set well above the slowest correct run. That run has every command
  // scanning the whole table, every gap at its longest, and a drain at each phase end.
  initial begin
    #WATCHDOG_TIME;
    $display("testbench: timeout with %0d results still pending", pending_results.size());
    $display("testbench: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("testbench: mismatch at %0t, %s: got %0h, expected %0h",
             $time, what, got, want);
    error_count++;
  endtask

  function automatic void reset_allowlist_model();
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      allow_addr[k] = '0;
      allow_time[k] = '0;
    end
  endfunction

  // Works out the outcome of one command and updates the modeled table the same way
  // the filter should update its own.
  function automatic filter_result_t predict_filter(input filter_cmd_t c);
    filter_result_t r;
    int             hit;
    bit             removed_any;
    r.status    = ST_ADDED;
    r.fwd       = 1'b0;
    r.listed    = 1'b0;
    r.seen      = '0;
    hit         = -1;
    removed_any = 1'b0;
    case (c.mode)
      MODE_ADD: begin
        // The first slot that is empty or already holds the address takes it.
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
          if (hit < 0 && (allow_addr[k] == '0 || allow_addr[k] == c.addr)) hit = k;
        end
        if (hit < 0) begin
          r.status = ST_FULL;
        end else begin
          allow_addr[hit] = c.addr;
          allow_time[hit] = '0;
        end
      end
      MODE_REMOVE: begin
        if (c.addr != '0) begin
          for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (allow_addr[k] == c.addr) begin
              allow_addr[k] = '0;
              allow_time[k] = '0;
              removed_any   = 1'b1;
            end
          end
        end
        r.status = removed_any ? ST_REMOVED : ST_NOT_FOUND;
      end
      MODE_CLEAR: begin
        reset_allowlist_model();
        r.status = ST_CLEARED;
      end
      default: begin
        if (c.addr != '0) begin
          for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (hit < 0 && allow_addr[k] == c.addr) hit = k;
          end
        end
        if (hit < 0) begin
          r.status = ST_UNLISTED;
        end else begin
          r.listed = 1'b1;
          r.seen   = allow_time[hit];
          // The checks run in a fixed order: the interval first, then the length.
          if (c.now < allow_time[hit] ||
              (c.now - allow_time[hit]) < TIME_W'(rule_min_interval)) begin
            r.status = ST_TOO_SOON;
          end else if (c.len > rule_max_length) begin
            r.status = ST_TOO_LARGE;
          end else begin
            allow_time[hit] = c.now;
            r.fwd           = 1'b1;
            r.status        = ST_FORWARDED;
          end
        end
      end
    endcase
    return r;
  endfunction

  // Presents one command and holds start until the command transfer happens. start is
  // left high on return, so a caller can send the next command back to back. A row with
  // a hand-written outcome queues that outcome, but the predictor still runs so that its
  // table stays in step with the filter.
  task automatic issue_command(input filter_cmd_t c, input bit known_result,
                               input filter_result_t known);
    filter_result_t predicted;
    start             <= 1'b1;
    in_mode           <= c.mode;
    in_dev_addr       <= c.addr;
    in_now_time       <= c.now;
    in_payload_length <= c.len;
    do @(posedge clk); while (busy);
    predicted = predict_filter(c);
    if (known_result) begin
      pending_results.push_back(known);
    end else begin
      pending_results.push_back(predicted);
    end
    commands_sent++;
  endtask

  // Writes one register. cfg_valid is left high, so the caller lowers it after the last
  // write of a group.
  task automatic write_rule(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MIN_INTERVAL: rule_min_interval = data;
      CFG_MAX_LENGTH:   rule_max_length   = data[LEN_W-1:0];
      default: ;
    endcase
  endtask

  // Stops sending and waits until every predicted result has been checked. A margin
  // follows, so that no scan is still running when the rules change.
  task automatic wait_for_drain();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random traffic is mostly well formed. Packets go to a small pool of addresses, so
  // they hit listed devices, and their time is often placed right at the edge of the
  // interval. About one command in ten is noise over the full range of every field.
  function automatic filter_cmd_t next_random_cmd();
    filter_cmd_t       c;
    logic [63:0]       wide;
    logic [TIME_W-1:0] last;
    int                pick;
    wide   = {$urandom(), $urandom()};
    pick   = $urandom_range(0, 99);
    c.mode = MODE_PACKET;
    c.addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    c.now  = wide[TIME_W-1:0];
    c.len  = LEN_W'($urandom());
    if (pick < 55) begin
      last = '0;
      for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
        if (allow_addr[k] == c.addr) last = allow_time[k];
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4:
          c.now = last + TIME_W'(rule_min_interval) + TIME_W'($urandom_range(0, 4))
                  - TIME_W'(2);
        5, 6: begin
          sweep_clock = sweep_clock + (TIME_W'(rule_min_interval) >> $urandom_range(0, 2))
                        + TIME_W'($urandom_range(0, 50));
          c.now = sweep_clock;
        end
        7: c.now = last - TIME_W'($urandom_range(1, 5000));
        8: ;
        default: c.now = last + TIME_W'(rule_min_interval) + TIME_W'(wide[39:0]);
      endcase
      case ($urandom_range(0, 3))
        0: c.len = rule_max_length;
        1: c.len = rule_max_length + LEN_W'(1);
        default: ;
      endcase
    end else if (pick < 75) begin
      c.mode = MODE_ADD;
    end else if (pick < 87) begin
      c.mode = MODE_REMOVE;
    end else if (pick < 90) begin
      c.mode = MODE_CLEAR;
    end else begin
      c.mode = mode_t'($urandom_range(0, 3));
      c.addr = ($urandom_range(0, 3) == 0) ? '0 : ADDR_W'($urandom());
    end
    return c;
  endfunction

  // The monitor checks a result in the cycle of its strobe. The receiver can never stall.
  always @(posedge clk) begin : check_results
    filter_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, status", 64'(out_status), 64'd0);
      end else begin
        want = pending_results.pop_front();
        status_tally[want.status]++;
        if (out_status !== want.status)
          report_mismatch("status", 64'(out_status), 64'(want.status));
        if (out_forward !== want.fwd)
          report_mismatch("forward", 64'(out_forward), 64'(want.fwd));
        if (out_listed !== want.listed)
          report_mismatch("listed", 64'(out_listed), 64'(want.listed));
        if (out_last_seen !== want.seen)
          report_mismatch("last_seen", 64'(out_last_seen), 64'(want.seen));
      end
    end
  end

  initial begin : stimulus
    filter_cmd_t           c;
    filter_result_t        known;
    logic [CFG_DATA_W-1:0] min_word;
    logic [CFG_DATA_W-1:0] len_word;
    int                    items_left;
    int                    burst;
    int                    drain_point;

    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_mode           <= MODE_ADD;
    in_dev_addr       <= '0;
    in_now_time       <= '0;
    in_payload_length <= '0;
    cfg_valid         <= 1'b0;
    cfg_index         <= CFG_MIN_INTERVAL;
    cfg_wdata         <= '0;
    error_count       = 0;
    commands_sent     = 0;
    sweep_clock       = '0;
    foreach (status_tally[s]) status_tally[s] = 0;
    reset_allowlist_model();
    rule_min_interval = MIN_INTERVAL_RST;
    rule_max_length   = MAX_LENGTH_RST;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // The opening table is sent back to back, under the reset rules.
    foreach (opening_plan[i]) begin
      known = '{opening_plan[i].status, opening_plan[i].fwd, opening_plan[i].listed,
                opening_plan[i].seen};
      for (int k = 0; k < opening_plan[i].reps; k++) begin
        c = '{opening_plan[i].mode, opening_plan[i].addr + ADDR_W'(k),
              opening_plan[i].now, opening_plan[i].len};
        issue_command(c, opening_plan[i].known_result, known);
      end
    end

    for (int phase = 0; phase < RULE_PHASES; phase++) begin
      wait_for_drain();
      // The settings cover both ends of each register. Where only the low byte of the
      // length word matters, the upper bits still carry data that must be dropped.
      case (phase)
        0: begin min_word = MIN_INTERVAL_RST; len_word = CFG_DATA_W'(MAX_LENGTH_RST); end
        1: begin min_word = '0; len_word = '0; end
        2: begin min_word = '1; len_word = '1; end
        3: begin min_word = '0; len_word = {24'($urandom()), 8'hFF}; end
        4: begin min_word = '1; len_word = {24'($urandom()), 8'h00}; end
        5: begin min_word = $urandom_range(1, 500); len_word = $urandom(); end
        6: begin min_word = $urandom(); len_word = $urandom(); end
        default: begin
          min_word = $urandom_range(500, 5000);
          len_word = $urandom_range(100, 200);
        end
      endcase
      write_rule(CFG_MIN_INTERVAL, min_word);
      write_rule(CFG_MAX_LENGTH, len_word);
      // A write to an unmapped index must leave both rules alone.
      write_rule(CFG_IDX_W'($urandom_range(CFG_FIRST_UNMAPPED, {CFG_IDX_W{1'b1}})),
                 $urandom());
      cfg_valid <= 1'b0;

      foreach (addr_pool[i]) addr_pool[i] = $urandom();
      addr_pool[0] = '1;
      addr_pool[1] = ADDR_W'(1);
      sweep_clock  = {TIME_W{1'b0}} | TIME_W'({$urandom(), $urandom()} >> 17);

      // Commands go out in bursts separated by gaps. Some bursts are long enough to run
      // free for a good while. Once per phase the sender also stops until the filter has
      // drained, at a random point.
      items_left  = PHASE_ITEMS;
      drain_point = $urandom_range(20, PHASE_ITEMS - 20);
      while (items_left > 0) begin
        burst = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                            : $urandom_range(1, 12);
        while (burst > 0 && items_left > 0) begin
          issue_command(next_random_cmd(), 1'b0, known);
          burst--;
          items_left--;
          if (items_left == drain_point) wait_for_drain();
        end
        start <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end

    wait_for_drain();
    $display("testbench: %0d commands, %0d rule sets, %0d forwarded, %0d too soon, %0d too large",
             commands_sent, RULE_PHASES + 1, status_tally[ST_FORWARDED],
             status_tally[ST_TOO_SOON], status_tally[ST_TOO_LARGE]);
    $display("testbench: %0d unlisted, %0d added, %0d full, %0d removed, %0d absent, %0d cleared",
             status_tally[ST_UNLISTED], status_tally[ST_ADDED], status_tally[ST_FULL],
             status_tally[ST_REMOVED], status_tally[ST_NOT_FOUND], status_tally[ST_CLEARED]);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/dalrf_pkg.sv
rtl/dalrf_ram.sv
rtl/device_allowlist_rate_filter.sv
tb/sv/testbench.sv
